[design/eyrm_pkg.sv]
// Shared types, constants and helpers for the Euler-angle to rotation-matrix block.
// Depends on nothing; every design file refers to it by scoped names.
package eyrm_pkg;

  localparam int CordicStages = 16;
  localparam int AtanEntries  = 24;
  localparam int NumStages    = (CordicStages < AtanEntries) ? CordicStages : AtanEntries;
  localparam int QW           = 34;  // Q2.30 plus headroom for CORDIC growth

  localparam logic signed [QW-1:0] Q30Pi     = 34'sd3373259426;
  localparam logic signed [QW-1:0] Q30HalfPi = 34'sd1686629713;
  localparam logic signed [QW-1:0] Q30Gain   = 34'sd652032874;
  localparam logic signed [15:0]   Q14One    = 16'sd16384;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } eyrm_in_t;

  typedef struct packed {
    logic signed [15:0] r_row0_col0;
    logic signed [15:0] r_row0_col1;
    logic signed [15:0] r_row0_col2;
    logic signed [15:0] r_row1_col0;
    logic signed [15:0] r_row1_col1;
    logic signed [15:0] r_row1_col2;
    logic signed [15:0] r_row2_col0;
    logic signed [15:0] r_row2_col1;
    logic signed [15:0] r_row2_col2;
  } eyrm_out_t;

  typedef struct packed {
    logic signed [QW-1:0] s;
    logic signed [QW-1:0] c;
  } sincos_t;

  function automatic logic signed [QW-1:0] atan_q30(input int idx);
    logic [31:0] t;
    begin
      case (idx)
        0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
        3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
        6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
        9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
        12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
        15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
        18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
        21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
        default: t = 32'h0;
      endcase
      atan_q30 = $signed({2'b00, t});
    end
  endfunction

  // Q2.30 product, half rounds up.
  function automatic logic signed [QW-1:0] mul30(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    begin
      p = a * b + (68'sd1 <<< 29);
      mul30 = QW'(p >>> 30);
    end
  endfunction

  // Q2.30 to Q2.14 with rounding and clamp to +/- one.
  function automatic logic signed [15:0] to_q14(input logic signed [QW+1:0] v);
    logic signed [QW+1:0] r;
    begin
      r = (v + 36'sd32768) >>> 16;
      if (r > 36'sd16384) to_q14 = Q14One;
      else if (r < -36'sd16384) to_q14 = -Q14One;
      else to_q14 = r[15:0];
    end
  endfunction

endpackage

[design/eyrm_cordic.sv]
// Pipelined rotation-mode CORDIC with range reduction: one angle in, sin/cos out.
// Depends on eyrm_pkg. Takes one angle per cycle.
module eyrm_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [15:0]               angle_i,
  output logic                             valid_o,
  output eyrm_pkg::sincos_t                sc_o
);
  localparam int N = eyrm_pkg::NumStages;
  localparam int W = eyrm_pkg::QW;

  logic signed [W-1:0] x_q [N+1];
  logic signed [W-1:0] y_q [N+1];
  logic signed [W-1:0] z_q [N+1];
  logic                flip_q [N+1];
  logic [N+1:0]        vld_q;
  logic signed [W-1:0] z_in;
  eyrm_pkg::sincos_t   sc_q;

  assign z_in = W'(angle_i) <<< 17;

  // Range reduction stage, then one register stage per iteration.
  always_ff @(posedge clk_i) begin
    x_q[0] <= eyrm_pkg::Q30Gain;
    y_q[0] <= '0;
    if (z_in > eyrm_pkg::Q30HalfPi) begin
      z_q[0] <= z_in - eyrm_pkg::Q30Pi;
      flip_q[0] <= 1'b1;
    end else if (z_in < -eyrm_pkg::Q30HalfPi) begin
      z_q[0] <= z_in + eyrm_pkg::Q30Pi;
      flip_q[0] <= 1'b1;
    end else begin
      z_q[0] <= z_in;
      flip_q[0] <= 1'b0;
    end
    for (int i = 0; i < N; i++) begin
      flip_q[i+1] <= flip_q[i];
      if (!z_q[i][W-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - eyrm_pkg::atan_q30(i);
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + eyrm_pkg::atan_q30(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sc_q.s <= flip_q[N] ? -y_q[N] : y_q[N];
    sc_q.c <= flip_q[N] ? -x_q[N] : x_q[N];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N:0], valid_i};
    end
  end

  assign valid_o = vld_q[N+1];
  assign sc_o    = sc_q;
endmodule

[design/eyrm_matrix.sv]
// Three-stage product and rounding pipeline forming the nine matrix entries.
// Depends on eyrm_pkg. Stages: pair products, triple products, sum and round.
module eyrm_matrix (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  eyrm_pkg::sincos_t    psi_i,
  input  eyrm_pkg::sincos_t    th_i,
  input  eyrm_pkg::sincos_t    phi_i,
  output logic                 valid_o,
  output eyrm_pkg::eyrm_out_t  mat_o
);
  localparam int W = eyrm_pkg::QW;
  typedef logic signed [W-1:0] q_t;
  typedef logic signed [W+1:0] qs_t;

  q_t ss_q, cs_q, e00_q, e01_q, e12_q, e22_q, nsth_q;
  q_t sps_q, cps_q, cph_q, sph_q;
  q_t a3_q, b3_q, a4_q, b4_q, a6_q, b6_q, a7_q, b7_q;
  q_t e00b_q, e01b_q, e12b_q, e22b_q, nsthb_q;
  logic [2:0] vld_q;
  eyrm_pkg::eyrm_out_t mat_q;

  always_ff @(posedge clk_i) begin
    ss_q   <= eyrm_pkg::mul30(phi_i.s, th_i.s);
    cs_q   <= eyrm_pkg::mul30(phi_i.c, th_i.s);
    e00_q  <= eyrm_pkg::mul30(th_i.c, psi_i.c);
    e01_q  <= eyrm_pkg::mul30(th_i.c, psi_i.s);
    e12_q  <= eyrm_pkg::mul30(phi_i.s, th_i.c);
    e22_q  <= eyrm_pkg::mul30(phi_i.c, th_i.c);
    nsth_q <= -th_i.s;
    sps_q  <= psi_i.s;
    cps_q  <= psi_i.c;
    cph_q  <= phi_i.c;
    sph_q  <= phi_i.s;

    a3_q <= eyrm_pkg::mul30(ss_q, cps_q);
    b3_q <= eyrm_pkg::mul30(cph_q, sps_q);
    a4_q <= eyrm_pkg::mul30(ss_q, sps_q);
    b4_q <= eyrm_pkg::mul30(cph_q, cps_q);
    a6_q <= eyrm_pkg::mul30(cs_q, cps_q);
    b6_q <= eyrm_pkg::mul30(sph_q, sps_q);
    a7_q <= eyrm_pkg::mul30(cs_q, sps_q);
    b7_q <= eyrm_pkg::mul30(sph_q, cps_q);
    e00b_q <= e00_q; e01b_q <= e01_q; e12b_q <= e12_q; e22b_q <= e22_q;
    nsthb_q <= nsth_q;

    mat_q.r_row0_col0 <= eyrm_pkg::to_q14(qs_t'(e00b_q));
    mat_q.r_row0_col1 <= eyrm_pkg::to_q14(qs_t'(e01b_q));
    mat_q.r_row0_col2 <= eyrm_pkg::to_q14(qs_t'(nsthb_q));
    mat_q.r_row1_col0 <= eyrm_pkg::to_q14(qs_t'(a3_q) - qs_t'(b3_q));
    mat_q.r_row1_col1 <= eyrm_pkg::to_q14(qs_t'(a4_q) + qs_t'(b4_q));
    mat_q.r_row1_col2 <= eyrm_pkg::to_q14(qs_t'(e12b_q));
    mat_q.r_row2_col0 <= eyrm_pkg::to_q14(qs_t'(a6_q) + qs_t'(b6_q));
    mat_q.r_row2_col1 <= eyrm_pkg::to_q14(qs_t'(a7_q) - qs_t'(b7_q));
    mat_q.r_row2_col2 <= eyrm_pkg::to_q14(qs_t'(e22b_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign mat_o   = mat_q;
endmodule

[design/euler_ypr_to_rotation_matrix_top.sv]
// Top level: yaw/pitch/roll in Q3.13 to the ZYX world-to-body rotation matrix in Q2.14.
// Depends on eyrm_pkg, eyrm_cordic and eyrm_matrix.
//
// Usage:
//   Input channel: drive angles_i and pulse start. A transaction is taken
//   at each rising edge with start high and busy low. busy is tied low:
//   the pipeline takes one transaction every cycle, back to back.
//   Output channel: done_o is high for exactly one cycle with the nine
//   entries on matrix_o. The receiver cannot stall; it must capture then.
//   Path from accept to done_o: one range-reduction stage, one stage per
//   CORDIC iteration, one sign-fix stage, then three product/round stages.
//   Throughput: one transaction per cycle, set by the fully unrolled CORDIC
//   and the three-stage multiplier pipeline.
//   Reset: rst_ni clears all valid bits; items in flight are dropped.
//   No state is kept between transactions.
module euler_ypr_to_rotation_matrix_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  eyrm_pkg::eyrm_in_t   angles_i,
  output logic                 done_o,
  output eyrm_pkg::eyrm_out_t  matrix_o
);
  logic accept;
  logic [2:0] cv;
  eyrm_pkg::sincos_t psi, th, phi;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Three identical CORDIC lanes run in lockstep.
  eyrm_cordic u_psi (.clk_i, .rst_ni, .valid_i(accept), .angle_i(angles_i.yaw),
                     .valid_o(cv[0]), .sc_o(psi));
  eyrm_cordic u_th  (.clk_i, .rst_ni, .valid_i(accept), .angle_i(angles_i.pitch),
                     .valid_o(cv[1]), .sc_o(th));
  eyrm_cordic u_phi (.clk_i, .rst_ni, .valid_i(accept), .angle_i(angles_i.roll),
                     .valid_o(cv[2]), .sc_o(phi));

  eyrm_matrix u_mat (.clk_i, .rst_ni, .valid_i(cv[0]), .psi_i(psi), .th_i(th),
                     .phi_i(phi), .valid_o(done_o), .mat_o(matrix_o));

  // Lanes must agree on valid.
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[0] == cv[1] && cv[1] == cv[2]) else $error("CORDIC lanes out of step");
  // Entry r_row1_col1 stays within +/- one.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (matrix_o.r_row1_col1 <= eyrm_pkg::Q14One &&
                matrix_o.r_row1_col1 >= -eyrm_pkg::Q14One))
    else $error("matrix entry out of range");
  // A valid CORDIC result must reach done_o through the matrix pipeline.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv[0] |-> ##3 done_o) else $error("matrix pipeline lost a transaction");
endmodule

[tb/sv/tb_euler_ypr_to_rotation_matrix_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for euler_ypr_to_rotation_matrix_top.
// Depends on eyrm_pkg for the angle and matrix transaction types.
module tb_euler_ypr_to_rotation_matrix_top;

  localparam int  NumRandom  = 750;
  localparam int  DrainWait  = 40;    // extra wait after the last expected matrix
  localparam int  CycleLimit = 200000;
  localparam int  DirRows    = 14;
  localparam int  NumStg     = eyrm_pkg::CordicStages;
  localparam longint PiQ30   = 64'sd3373259426;
  localparam longint HalfPi  = 64'sd1686629713;
  localparam longint GainQ30 = 64'sd652032874;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  eyrm_pkg::eyrm_in_t  angles_i = '0;
  logic                done_o;
  eyrm_pkg::eyrm_out_t matrix_o;

  eyrm_pkg::eyrm_out_t matrix_q[$];
  int        errors = 0;
  int        cycles = 0;
  int        sender_idle_pct = 8;

  // Directed table: angles, whether an expected matrix is typed in, that matrix.
  eyrm_pkg::eyrm_in_t  dir_ang [DirRows];
  bit                  dir_fix [DirRows];
  eyrm_pkg::eyrm_out_t dir_mat [DirRows];

  euler_ypr_to_rotation_matrix_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .angles_i (angles_i),
    .done_o   (done_o),
    .matrix_o (matrix_o)
  );

  always #10 clk_i = ~clk_i;

  // Floor shift, same as >>> on a signed longint.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
      64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return tbl[i];
  endfunction

  // Range reduction by pi, then rotation-mode CORDIC in Q2.30.
  function automatic void angle_sincos(input logic signed [15:0] ang,
                                       output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'(ang) * 131072;
    x = GainQ30;
    y = 0;
    flip = 1'b0;
    if (z > HalfPi) begin
      z -= PiQ30;
      flip = 1'b1;
    end else if (z < -HalfPi) begin
      z += PiQ30;
      flip = 1'b1;
    end
    for (int i = 0; i < NumStg && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return floor_shr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic logic signed [15:0] q14_sat(longint v);
    longint r;
    r = floor_shr(v + 32768, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic eyrm_pkg::eyrm_out_t dcm_predict(eyrm_pkg::eyrm_in_t a);
    longint sps, cps, sth, cth, sph, cph, ss, cs;
    eyrm_pkg::eyrm_out_t m;
    angle_sincos(a.yaw, sps, cps);
    angle_sincos(a.pitch, sth, cth);
    angle_sincos(a.roll, sph, cph);
    ss = q30_mul(sph, sth);
    cs = q30_mul(cph, sth);
    m.r_row0_col0 = q14_sat(q30_mul(cth, cps));
    m.r_row0_col1 = q14_sat(q30_mul(cth, sps));
    m.r_row0_col2 = q14_sat(-sth);
    m.r_row1_col0 = q14_sat(q30_mul(ss, cps) - q30_mul(cph, sps));
    m.r_row1_col1 = q14_sat(q30_mul(ss, sps) + q30_mul(cph, cps));
    m.r_row1_col2 = q14_sat(q30_mul(sph, cth));
    m.r_row2_col0 = q14_sat(q30_mul(cs, cps) + q30_mul(sph, sps));
    m.r_row2_col1 = q14_sat(q30_mul(cs, sps) - q30_mul(sph, cps));
    m.r_row2_col2 = q14_sat(q30_mul(cph, cth));
    return m;
  endfunction

  // One transaction: start held through the accepting edge; lowered at the
  // next falling edge only if the following item is not back to back.
  task automatic send_angles(eyrm_pkg::eyrm_in_t a, eyrm_pkg::eyrm_out_t exp_m);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    angles_i <= a;
    start    <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    matrix_q = {matrix_q, exp_m};
    @(negedge clk_i);
  endtask

  // Result checker: compare each strobed matrix with the oldest expectation.
  always @(posedge clk_i) begin
    eyrm_pkg::eyrm_out_t e;
    cycles <= cycles + 1;
    if (rst_ni && done_o) begin
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected matrix %h", $time, matrix_o);
        errors++;
      end else begin
        e = matrix_q.pop_front();
        if (e.r_row0_col0 !== matrix_o.r_row0_col0) begin
          $display("%0t: r00 exp %0d got %0d", $time, e.r_row0_col0, matrix_o.r_row0_col0);
          errors++;
        end
        if (e.r_row0_col1 !== matrix_o.r_row0_col1) begin
          $display("%0t: r01 exp %0d got %0d", $time, e.r_row0_col1, matrix_o.r_row0_col1);
          errors++;
        end
        if (e.r_row0_col2 !== matrix_o.r_row0_col2) begin
          $display("%0t: r02 exp %0d got %0d", $time, e.r_row0_col2, matrix_o.r_row0_col2);
          errors++;
        end
        if (e.r_row1_col0 !== matrix_o.r_row1_col0) begin
          $display("%0t: r10 exp %0d got %0d", $time, e.r_row1_col0, matrix_o.r_row1_col0);
          errors++;
        end
        if (e.r_row1_col1 !== matrix_o.r_row1_col1) begin
          $display("%0t: r11 exp %0d got %0d", $time, e.r_row1_col1, matrix_o.r_row1_col1);
          errors++;
        end
        if (e.r_row1_col2 !== matrix_o.r_row1_col2) begin
          $display("%0t: r12 exp %0d got %0d", $time, e.r_row1_col2, matrix_o.r_row1_col2);
          errors++;
        end
        if (e.r_row2_col0 !== matrix_o.r_row2_col0) begin
          $display("%0t: r20 exp %0d got %0d", $time, e.r_row2_col0, matrix_o.r_row2_col0);
          errors++;
        end
        if (e.r_row2_col1 !== matrix_o.r_row2_col1) begin
          $display("%0t: r21 exp %0d got %0d", $time, e.r_row2_col1, matrix_o.r_row2_col1);
          errors++;
        end
        if (e.r_row2_col2 !== matrix_o.r_row2_col2) begin
          $display("%0t: r22 exp %0d got %0d", $time, e.r_row2_col2, matrix_o.r_row2_col2);
          errors++;
        end
      end
    end
  end

  // Watchdog: a stuck pipeline or lost strobe ends the run here.
  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic eyrm_pkg::eyrm_in_t mk_ang(int y, int p, int r);
    eyrm_pkg::eyrm_in_t a;
    a.yaw = 16'(y); a.pitch = 16'(p); a.roll = 16'(r);
    return a;
  endfunction

  // Random angles: mostly full range, some near zero, some near +/- pi/2
  // where range reduction switches, some at the 16-bit extremes.
  function automatic logic signed [15:0] rand_angle();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: return 16'($urandom_range(64) - 32);
      1: return 16'(12868 + $urandom_range(8) - 4);
      2: return 16'(-12868 + $urandom_range(8) - 4);
      3: return $urandom_range(1) ? 16'sh7FFF - 16'($urandom_range(3))
                                  : 16'sh8000 + 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    eyrm_pkg::eyrm_out_t ident;
    eyrm_pkg::eyrm_in_t  a;
    ident = '0;
    ident.r_row0_col0 = 16'sd16384;
    ident.r_row1_col1 = 16'sd16384;
    ident.r_row2_col2 = 16'sd16384;

    // Zero angles give the identity, read straight off the matrix form;
    // every other row goes through the predictor.
    dir_ang[0]  = mk_ang(0, 0, 0);            dir_fix[0] = 1;  dir_mat[0] = ident;
    dir_ang[1]  = mk_ang(32767, 0, 0);        dir_fix[1] = 0;
    dir_ang[2]  = mk_ang(-32768, 0, 0);       dir_fix[2] = 0;
    dir_ang[3]  = mk_ang(0, 32767, 0);        dir_fix[3] = 0;
    dir_ang[4]  = mk_ang(0, -32768, 0);       dir_fix[4] = 0;
    dir_ang[5]  = mk_ang(0, 0, 32767);        dir_fix[5] = 0;
    dir_ang[6]  = mk_ang(0, 0, -32768);       dir_fix[6] = 0;
    dir_ang[7]  = mk_ang(12868, 12868, 12868);    dir_fix[7] = 0;   // just past pi/2
    dir_ang[8]  = mk_ang(12867, -12867, 12867);   dir_fix[8] = 0;   // just below pi/2
    dir_ang[9]  = mk_ang(-12868, -12868, -12868); dir_fix[9] = 0;
    dir_ang[10] = mk_ang(32767, 32767, 32767);    dir_fix[10] = 0;  // gain overshoot
    dir_ang[11] = mk_ang(-32768, -32768, -32768); dir_fix[11] = 0;
    dir_ang[12] = mk_ang(25736, 6434, -6434);     dir_fix[12] = 0;  // ~pi, pi/4
    dir_ang[13] = mk_ang(1, -1, 1);               dir_fix[13] = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirRows; i++)
      send_angles(dir_ang[i], dir_fix[i] ? dir_mat[i] : dcm_predict(dir_ang[i]));

    // Three random phases: light sender idling, heavy idling, back to back.
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 70 : 0;
      for (int n = 0; n < NumRandom / 3; n++) begin
        a.yaw = rand_angle(); a.pitch = rand_angle(); a.roll = rand_angle();
        send_angles(a, dcm_predict(a));
      end
    end
    start <= 1'b0;

    while (matrix_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (errors == 0 && matrix_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
design/eyrm_pkg.sv
design/eyrm_cordic.sv
design/eyrm_matrix.sv
design/euler_ypr_to_rotation_matrix_top.sv
tb/sv/tb_euler_ypr_to_rotation_matrix_top.sv
